// ===== rtl/kmhid_pkg.sv =====
package kmhid_pkg;

  localparam int KEY_SLOTS      = 6;
  localparam int CONSUMER_SLOTS = 4;
  localparam int ROW_COUNT      = 5;
  localparam int COLUMN_COUNT   = 14;
  localparam int FN_ROW         = 4;
  localparam int FN_COL         = 1;
  localparam int HALF_COLS      = COLUMN_COUNT / 2;
  localparam int NUM_GROUPS     = ROW_COUNT * 2;
  localparam int CON_LIST       = 4;

  localparam logic [7:0] ROLLOVER_ERR = 8'h01;
  localparam logic [2:0] KEY_CNT_MAX  = 3'(KEY_SLOTS + 1);

  typedef enum logic [1:0] {
    ACT_BLANK,
    ACT_MOD,
    ACT_KEY,
    ACT_CON
  } act_kind_t;

  typedef struct packed {
    act_kind_t   kind;
    logic [15:0] code;
  } cell_action_t;

  typedef struct packed {
    logic [13:0] row_4_switches;
    logic [13:0] row_3_switches;
    logic [13:0] row_2_switches;
    logic [13:0] row_1_switches;
    logic [13:0] row_0_switches;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  modifier_byte;
    logic [7:0]  key_slot_0;
    logic [7:0]  key_slot_1;
    logic [7:0]  key_slot_2;
    logic [7:0]  key_slot_3;
    logic [7:0]  key_slot_4;
    logic [7:0]  key_slot_5;
    logic [2:0]  consumer_count;
    logic [15:0] consumer_slot_0;
    logic [15:0] consumer_slot_1;
    logic [15:0] consumer_slot_2;
    logic [15:0] consumer_slot_3;
  } out_item_t;

  typedef struct packed {
    logic        key_hit;
    logic        con_hit;
    logic [15:0] code;
  } cell_t;

  typedef struct packed {
    logic [KEY_SLOTS-1:0][7:0] code;
    logic [2:0]                cnt;
  } key_list_t;

  typedef struct packed {
    logic [CON_LIST-1:0][15:0] code;
    logic [2:0]                cnt;
  } con_list_t;

  typedef struct packed {
    key_list_t keys;
    con_list_t cons;
  } group_t;

  typedef struct packed {
    cell_t [ROW_COUNT-1:0][COLUMN_COUNT-1:0] cells;
    logic [7:0]                              mods;
  } s1_t;

  typedef struct packed {
    group_t [NUM_GROUPS-1:0] grp;
    logic [7:0]              mods;
  } s2_t;

  function automatic cell_action_t act_key(input logic [15:0] u);
    act_key = '{kind: ACT_KEY, code: u};
  endfunction

  function automatic cell_action_t act_mod(input logic [15:0] u);
    act_mod = '{kind: ACT_MOD, code: u};
  endfunction

  function automatic cell_action_t act_con(input logic [15:0] u);
    act_con = '{kind: ACT_CON, code: u};
  endfunction

  localparam cell_action_t NO_ACT = '{kind: ACT_BLANK, code: 16'h0000};

  localparam cell_action_t BASE_MAP [ROW_COUNT][COLUMN_COUNT] = '{
    '{act_key(16'h29), act_key(16'h1E), act_key(16'h1F), act_key(16'h20),
      act_key(16'h21), act_key(16'h22), act_key(16'h23), act_key(16'h24),
      act_key(16'h25), act_key(16'h26), act_key(16'h27), act_key(16'h2D),
      act_key(16'h2E), act_key(16'h2A)},
    '{act_key(16'h2B), act_key(16'h14), act_key(16'h1A), act_key(16'h08),
      act_key(16'h15), act_key(16'h17), act_key(16'h1C), act_key(16'h18),
      act_key(16'h0C), act_key(16'h12), act_key(16'h13), act_key(16'h2F),
      act_key(16'h30), act_key(16'h31)},
    '{act_key(16'h39), act_key(16'h04), act_key(16'h16), act_key(16'h07),
      act_key(16'h09), act_key(16'h0A), act_key(16'h0B), act_key(16'h0D),
      act_key(16'h0E), act_key(16'h0F), act_key(16'h33), act_key(16'h34),
      act_key(16'h28), NO_ACT},
    '{act_mod(16'h02), act_key(16'h1D), act_key(16'h1B), act_key(16'h06),
      act_key(16'h19), act_key(16'h05), act_key(16'h11), act_key(16'h10),
      act_key(16'h36), act_key(16'h37), act_key(16'h38), act_key(16'h52),
      act_mod(16'h20), NO_ACT},
    '{act_mod(16'h01), NO_ACT, act_mod(16'h08), act_mod(16'h04),
      act_key(16'h2C), act_key(16'h2C), act_mod(16'h40), act_key(16'h65),
      NO_ACT, act_key(16'h50), act_key(16'h51), act_key(16'h4F),
      NO_ACT, NO_ACT}
  };

  localparam cell_action_t FN_MAP [ROW_COUNT][COLUMN_COUNT] = '{
    '{act_key(16'h35), act_key(16'h3A), act_key(16'h3B), act_key(16'h3C),
      act_key(16'h3D), act_key(16'h3E), act_key(16'h3F), act_key(16'h40),
      act_key(16'h41), act_key(16'h42), act_key(16'h43), NO_ACT,
      NO_ACT, act_key(16'h4C)},
    '{NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT,
      NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT},
    '{NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT,
      NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT},
    '{NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT,
      NO_ACT, NO_ACT, NO_ACT, NO_ACT, act_con(16'h006F), NO_ACT, NO_ACT},
    '{NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT, NO_ACT,
      NO_ACT, NO_ACT, act_con(16'h00EA), act_con(16'h0070), act_con(16'h00E9),
      NO_ACT, NO_ACT}
  };

  // Appends list b behind list a. Lists are zero beyond their counts.
  function automatic group_t merge_group(input group_t a, input group_t b);
    group_t     r;
    logic [3:0] ksum;
    logic [3:0] csum;
    r    = '0;
    ksum = {1'b0, a.keys.cnt} + {1'b0, b.keys.cnt};
    csum = {1'b0, a.cons.cnt} + {1'b0, b.cons.cnt};
    r.keys.cnt = (ksum > 4'(KEY_SLOTS)) ? KEY_CNT_MAX : ksum[2:0];
    r.cons.cnt = (csum > 4'(CONSUMER_SLOTS)) ? 3'(CONSUMER_SLOTS) : csum[2:0];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (i < int'(a.keys.cnt)) begin
        r.keys.code[i] = a.keys.code[i];
      end else begin
        for (int j = 0; j < KEY_SLOTS; j++) begin
          if (j + int'(a.keys.cnt) == i) begin
            r.keys.code[i] = b.keys.code[j];
          end
        end
      end
    end
    for (int i = 0; i < CONSUMER_SLOTS; i++) begin
      if (i < int'(a.cons.cnt)) begin
        r.cons.code[i] = a.cons.code[i];
      end else begin
        for (int j = 0; j < CONSUMER_SLOTS; j++) begin
          if (j + int'(a.cons.cnt) == i) begin
            r.cons.code[i] = b.cons.code[j];
          end
        end
      end
    end
    merge_group = r;
  endfunction

endpackage

// ===== rtl/kmhid_lookup.sv =====
module kmhid_lookup
  import kmhid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output s1_t      out_data
);

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic [ROW_COUNT-1:0][COLUMN_COUNT-1:0] rows;
    logic                                   fn_held;
    cell_action_t                           a;
    rows     = {in_data.row_4_switches, in_data.row_3_switches,
                in_data.row_2_switches, in_data.row_1_switches,
                in_data.row_0_switches};
    fn_held  = rows[FN_ROW][FN_COL];
    data_nxt = '0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      for (int c = 0; c < COLUMN_COUNT; c++) begin
        a = BASE_MAP[r][c];
        if (fn_held && FN_MAP[r][c].kind != ACT_BLANK) begin
          a = FN_MAP[r][c];
        end
        if (!rows[r][c] || (r == FN_ROW && c == FN_COL)) begin
          a = NO_ACT;
        end
        data_nxt.cells[r][c].key_hit = (a.kind == ACT_KEY);
        data_nxt.cells[r][c].con_hit = (a.kind == ACT_CON);
        data_nxt.cells[r][c].code    = a.code;
        if (a.kind == ACT_MOD) begin
          data_nxt.mods = data_nxt.mods | a.code[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/kmhid_compact.sv =====
module kmhid_compact
  import kmhid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_data
);

  logic valid_r;
  s2_t  data_r;
  s2_t  data_nxt;

  // Packs the pressed cells of one half row into scan-ordered lists.
  function automatic group_t compact_group(input cell_t [HALF_COLS-1:0] cells);
    group_t g;
    g = '0;
    for (int k = 0; k < HALF_COLS; k++) begin
      if (cells[k].key_hit) begin
        for (int s = 0; s < KEY_SLOTS; s++) begin
          if (s == int'(g.keys.cnt)) begin
            g.keys.code[s] = cells[k].code[7:0];
          end
        end
        if (g.keys.cnt != KEY_CNT_MAX) begin
          g.keys.cnt = g.keys.cnt + 3'd1;
        end
      end
      if (cells[k].con_hit && int'(g.cons.cnt) < CONSUMER_SLOTS) begin
        for (int s = 0; s < CONSUMER_SLOTS; s++) begin
          if (s == int'(g.cons.cnt)) begin
            g.cons.code[s] = cells[k].code;
          end
        end
        g.cons.cnt = g.cons.cnt + 3'd1;
      end
    end
    compact_group = g;
  endfunction

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt      = '0;
    data_nxt.mods = in_data.mods;
    for (int r = 0; r < ROW_COUNT; r++) begin
      for (int h = 0; h < 2; h++) begin
        data_nxt.grp[r*2+h] = compact_group(in_data.cells[r][h*HALF_COLS +: HALF_COLS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/kmhid_merge.sv =====
module kmhid_merge
  import kmhid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  s2_t       in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic                   row_valid_r;
  group_t [ROW_COUNT-1:0] row_r;
  group_t [ROW_COUNT-1:0] row_nxt;
  logic [7:0]             row_mods_r;
  logic                   pair_valid_r;
  group_t [2:0]           pair_r;
  group_t [2:0]           pair_nxt;
  logic [7:0]             pair_mods_r;
  logic                   res_valid_r;
  out_item_t              res_r;
  out_item_t              res_nxt;
  logic                   res_ready;
  logic                   pair_ready;
  logic                   row_ready;

  assign res_ready  = !res_valid_r || out_ready;
  assign pair_ready = !pair_valid_r || res_ready;
  assign row_ready  = !row_valid_r || pair_ready;
  assign in_ready   = row_ready;
  assign out_valid  = res_valid_r;
  assign out_data   = res_r;

  always_comb begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      row_nxt[r] = merge_group(in_data.grp[r*2], in_data.grp[r*2+1]);
    end
  end

  always_comb begin
    pair_nxt[0] = merge_group(row_r[0], row_r[1]);
    pair_nxt[1] = merge_group(row_r[2], row_r[3]);
    pair_nxt[2] = row_r[4];
  end

  always_comb begin
    group_t all;
    logic   overflow;
    all      = merge_group(merge_group(pair_r[0], pair_r[1]), pair_r[2]);
    overflow = (all.keys.cnt > 3'(KEY_SLOTS));
    res_nxt.modifier_byte   = pair_mods_r;
    res_nxt.key_slot_0      = overflow ? ROLLOVER_ERR : all.keys.code[0];
    res_nxt.key_slot_1      = overflow ? ROLLOVER_ERR : all.keys.code[1];
    res_nxt.key_slot_2      = overflow ? ROLLOVER_ERR : all.keys.code[2];
    res_nxt.key_slot_3      = overflow ? ROLLOVER_ERR : all.keys.code[3];
    res_nxt.key_slot_4      = overflow ? ROLLOVER_ERR : all.keys.code[4];
    res_nxt.key_slot_5      = overflow ? ROLLOVER_ERR : all.keys.code[5];
    res_nxt.consumer_count  = all.cons.cnt;
    res_nxt.consumer_slot_0 = all.cons.code[0];
    res_nxt.consumer_slot_1 = all.cons.code[1];
    res_nxt.consumer_slot_2 = all.cons.code[2];
    res_nxt.consumer_slot_3 = all.cons.code[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r  <= 1'b0;
      pair_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (row_ready) begin
        row_valid_r <= in_valid;
      end
      if (pair_ready) begin
        pair_valid_r <= row_valid_r;
      end
      if (res_ready) begin
        res_valid_r <= pair_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_ready && in_valid) begin
      row_r      <= row_nxt;
      row_mods_r <= in_data.mods;
    end
    if (pair_ready && row_valid_r) begin
      pair_r      <= pair_nxt;
      pair_mods_r <= row_mods_r;
    end
    if (res_ready && pair_valid_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/key_matrix_to_hid_report_unit.sv =====
// Channel   Direction  Handshake                Payload
// in_       input      in_valid / in_ready      in_data  (in_item_t, five row bitmaps)
// out_      output     out_valid / out_ready    out_data (out_item_t, HID reports)
//
// One snapshot is taken per cycle while in_ready is high; the path runs through five
// registers: the lookup, half-row compaction, row merge, pair merge and final merge registers.
// Every stage has its own valid bit and moves when the stage after it is empty
// or moving, so bubbles close up while the output is stalled.
// Reset clears only the valid bits; a stall holds each stage without loss.
module key_matrix_to_hid_report_unit
  import kmhid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  kmhid_lookup u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  kmhid_compact u_compact (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  kmhid_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/kmhid_checker.sv =====
module kmhid_checker
  import kmhid_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_clears_out : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transfer changed");

  a_consumer_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.consumer_count <= 3'(CONSUMER_SLOTS))
    else $error("consumer count above slot count");

  a_consumer_tail : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.consumer_count < 3'd4 |-> out_data.consumer_slot_3 == 16'h0000)
    else $error("unused consumer slot not zero");

  a_rollover_all : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key_slot_0 == ROLLOVER_ERR |->
      out_data.key_slot_1 == ROLLOVER_ERR && out_data.key_slot_2 == ROLLOVER_ERR &&
      out_data.key_slot_3 == ROLLOVER_ERR && out_data.key_slot_4 == ROLLOVER_ERR &&
      out_data.key_slot_5 == ROLLOVER_ERR)
    else $error("partial rollover report");

endmodule

bind key_matrix_to_hid_report_unit kmhid_checker u_kmhid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/key_matrix_to_hid_report_unit_test.sv =====
module key_matrix_to_hid_report_unit_test;
  import kmhid_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [13:0] ALL_KEYS = 14'h3FFF;
  localparam logic [13:0] FN_KEY = 14'(1) << FN_COL;

  // Base-layer key usages; zero marks a modifier or an empty position.
  localparam logic [7:0] BASE_KEYS [ROW_COUNT][COLUMN_COUNT] = '{
    '{8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
      8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A},
    '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
      8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31},
    '{8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
      8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28, 8'h00},
    '{8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
      8'h10, 8'h36, 8'h37, 8'h38, 8'h52, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h2C, 8'h2C, 8'h00,
      8'h65, 8'h00, 8'h50, 8'h51, 8'h4F, 8'h00, 8'h00}
  };

  localparam logic [7:0] FN_TOP_KEYS [COLUMN_COUNT] = '{
    8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
    8'h40, 8'h41, 8'h42, 8'h43, 8'h00, 8'h00, 8'h4C
  };

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  out_item_t pending_reports [$];
  int        mismatch_count = 0;
  int        report_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  key_matrix_to_hid_report_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic cell_action_t lookup_cell(int r, int c, logic fn_held);
    cell_action_t act;
    act = '{kind: ACT_BLANK, code: 16'h0000};
    if (BASE_KEYS[r][c] != 8'h00) begin
      act = '{kind: ACT_KEY, code: 16'(BASE_KEYS[r][c])};
    end
    // Positions are coded as row * 16 + column.
    case (r * 16 + c)
      'h30: act = '{kind: ACT_MOD, code: 16'h0002};
      'h3C: act = '{kind: ACT_MOD, code: 16'h0020};
      'h40: act = '{kind: ACT_MOD, code: 16'h0001};
      'h42: act = '{kind: ACT_MOD, code: 16'h0008};
      'h43: act = '{kind: ACT_MOD, code: 16'h0004};
      'h46: act = '{kind: ACT_MOD, code: 16'h0040};
      default: ;
    endcase
    if (fn_held) begin
      if (r == 0 && FN_TOP_KEYS[c] != 8'h00) begin
        act = '{kind: ACT_KEY, code: 16'(FN_TOP_KEYS[c])};
      end
      case (r * 16 + c)
        'h3B: act = '{kind: ACT_CON, code: 16'h006F};
        'h49: act = '{kind: ACT_CON, code: 16'h00EA};
        'h4A: act = '{kind: ACT_CON, code: 16'h0070};
        'h4B: act = '{kind: ACT_CON, code: 16'h00E9};
        default: ;
      endcase
    end
    return act;
  endfunction

  function automatic out_item_t predict_report(in_item_t snap);
    logic [ROW_COUNT-1:0][COLUMN_COUNT-1:0] rows;
    logic [7:0]   keys [KEY_SLOTS];
    logic [15:0]  cons [CONSUMER_SLOTS];
    logic [7:0]   mods;
    int           nkeys;
    int           ncons;
    logic         overflow;
    logic         fn_held;
    cell_action_t act;
    out_item_t    rep;
    rows = snap;
    fn_held = rows[FN_ROW][FN_COL];
    mods = 8'h00;
    nkeys = 0;
    ncons = 0;
    overflow = 1'b0;
    foreach (keys[i]) keys[i] = 8'h00;
    foreach (cons[i]) cons[i] = 16'h0000;
    for (int r = 0; r < ROW_COUNT; r++) begin
      for (int c = 0; c < COLUMN_COUNT; c++) begin
        if (rows[r][c] && !(r == FN_ROW && c == FN_COL)) begin
          act = lookup_cell(r, c, fn_held);
          case (act.kind)
            ACT_MOD: mods |= act.code[7:0];
            ACT_KEY: begin
              if (nkeys < KEY_SLOTS) begin
                keys[nkeys] = act.code[7:0];
                nkeys++;
              end else begin
                overflow = 1'b1;
              end
            end
            ACT_CON: begin
              if (ncons < CONSUMER_SLOTS) begin
                cons[ncons] = act.code;
                ncons++;
              end
            end
            default: ;
          endcase
        end
      end
    end
    if (overflow) begin
      foreach (keys[i]) keys[i] = ROLLOVER_ERR;
    end
    rep.modifier_byte   = mods;
    rep.key_slot_0      = keys[0];
    rep.key_slot_1      = keys[1];
    rep.key_slot_2      = keys[2];
    rep.key_slot_3      = keys[3];
    rep.key_slot_4      = keys[4];
    rep.key_slot_5      = keys[5];
    rep.consumer_count  = 3'(ncons);
    rep.consumer_slot_0 = cons[0];
    rep.consumer_slot_1 = cons[1];
    rep.consumer_slot_2 = cons[2];
    rep.consumer_slot_3 = cons[3];
    return rep;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("report transfer %0d: %s", report_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  task automatic compare_report(input out_item_t got, input out_item_t want);
    check_field("modifier_byte", 16'(got.modifier_byte), 16'(want.modifier_byte));
    check_field("key_slot_0", 16'(got.key_slot_0), 16'(want.key_slot_0));
    check_field("key_slot_1", 16'(got.key_slot_1), 16'(want.key_slot_1));
    check_field("key_slot_2", 16'(got.key_slot_2), 16'(want.key_slot_2));
    check_field("key_slot_3", 16'(got.key_slot_3), 16'(want.key_slot_3));
    check_field("key_slot_4", 16'(got.key_slot_4), 16'(want.key_slot_4));
    check_field("key_slot_5", 16'(got.key_slot_5), 16'(want.key_slot_5));
    check_field("consumer_count", 16'(got.consumer_count), 16'(want.consumer_count));
    check_field("consumer_slot_0", got.consumer_slot_0, want.consumer_slot_0);
    check_field("consumer_slot_1", got.consumer_slot_1, want.consumer_slot_1);
    check_field("consumer_slot_2", got.consumer_slot_2, want.consumer_slot_2);
    check_field("consumer_slot_3", got.consumer_slot_3, want.consumer_slot_3);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("report transfer with no snapshot outstanding");
        end else begin
          want = pending_reports.pop_front();
          compare_report(out_data, want);
        end
        report_count++;
      end
      if (in_valid && in_ready) begin
        pending_reports.push_back(predict_report(in_data));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_matrix_to_hid_report_unit: mismatch");
      $finish;
    end
  end

  task automatic send_snapshot(input in_item_t snap);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= snap;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_rows(input logic [13:0] r0, input logic [13:0] r1,
                           input logic [13:0] r2, input logic [13:0] r3,
                           input logic [13:0] r4);
    in_item_t snap;
    snap.row_0_switches = r0;
    snap.row_1_switches = r1;
    snap.row_2_switches = r2;
    snap.row_3_switches = r3;
    snap.row_4_switches = r4;
    send_snapshot(snap);
  endtask

  task automatic wait_for_reports();
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic test_extremes();
    send_rows(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0000);
    send_rows(ALL_KEYS, ALL_KEYS, ALL_KEYS, ALL_KEYS, ALL_KEYS);
    send_rows(ALL_KEYS, ALL_KEYS, ALL_KEYS, ALL_KEYS, ALL_KEYS & ~FN_KEY);
    send_rows(ALL_KEYS, 14'h0000, 14'h0000, 14'h0000, 14'h0000);
    send_rows(14'h0000, ALL_KEYS, 14'h0000, 14'h0000, 14'h0000);
    send_rows(14'h0000, 14'h0000, ALL_KEYS, 14'h0000, 14'h0000);
    send_rows(14'h0000, 14'h0000, 14'h0000, ALL_KEYS, 14'h0000);
    send_rows(14'h0000, 14'h0000, 14'h0000, 14'h0000, ALL_KEYS);
    // Positions with no action in either layer.
    send_rows(14'h0000, 14'h0000, 14'h2000, 14'h2000, 14'h3100);
    send_rows(14'h0000, 14'h0000, 14'h2000, 14'h2000, 14'h3100 | FN_KEY);
    send_rows(14'h2001, 14'h0000, 14'h0000, 14'h0000, 14'h0000);
    send_rows(14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0030);
  endtask

  task automatic test_fn_layer();
    send_rows(14'h0000, 14'h0000, 14'h0000, 14'h0000, FN_KEY);
    send_rows(14'h003F, 14'h0000, 14'h0000, 14'h0000, FN_KEY);
    send_rows(14'h3800, 14'h0000, 14'h0000, 14'h0000, FN_KEY);
    send_rows(14'h0000, 14'h0000, 14'h0000, 14'h0800, 14'h0E00 | FN_KEY);
    send_rows(14'h0000, 14'h0000, 14'h0000, 14'h0800, 14'h0E00);
    send_rows(14'h0000, 14'h0008, 14'h0002, 14'h1001, 14'h0041 | FN_KEY);
  endtask

  task automatic test_key_rollover();
    send_rows(14'h0000, 14'h003F, 14'h0000, 14'h0000, 14'h0000);
    send_rows(14'h0000, 14'h007F, 14'h0000, 14'h1001, 14'h004D);
    send_rows(14'h0000, 14'h007F, 14'h0000, 14'h0800, 14'h0E00 | FN_KEY);
    send_rows(14'h0000, 14'h0000, 14'h0000, 14'h1001, 14'h004D);
  endtask

  task automatic test_random_traffic(input int count);
    logic [ROW_COUNT-1:0][COLUMN_COUNT-1:0] rows;
    int mode;
    int presses;
    for (int n = 0; n < count; n++) begin
      rows = '0;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        // Sparse chords reach every slot count without always rolling over.
        presses = $urandom_range(0, 8);
        repeat (presses) begin
          rows[$urandom_range(0, ROW_COUNT - 1)][$urandom_range(0, COLUMN_COUNT - 1)] = 1'b1;
        end
        rows[FN_ROW][FN_COL] = 1'($urandom_range(0, 1));
      end else if (mode < 8) begin
        for (int r = 0; r < ROW_COUNT; r++) rows[r] = 14'($urandom);
      end else begin
        rows[$urandom_range(0, ROW_COUNT - 1)] = 14'($urandom);
        rows[FN_ROW][FN_COL] = 1'($urandom_range(0, 1));
      end
      send_snapshot(in_item_t'(rows));
    end
  endtask

  task automatic test_drain_pause();
    test_random_traffic(8);
    in_valid <= 1'b0;
    wait_for_reports();
    test_random_traffic(8);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    recv_idle_pct = 47;
    test_extremes();
    test_fn_layer();
    test_key_rollover();
    test_drain_pause();
    test_random_traffic(170);
    send_idle_pct = 47;
    recv_idle_pct = 30;
    test_random_traffic(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(170);
    in_valid <= 1'b0;
    wait_for_reports();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("key_matrix_to_hid_report_unit: match");
    end else begin
      $display("key_matrix_to_hid_report_unit: mismatch");
    end
    $finish;
  end

endmodule
